>>> rtl/klfc_pkg.sv
// ---------------------------------------------------------------------------
// klfc_pkg: shared types and constants for the keypad LED frame composer
// Frame descriptor, base-pixel kinds, mode codes and the pixel color function.
// ---------------------------------------------------------------------------
`default_nettype none

package klfc_pkg;

    localparam int KEY_PIXELS   = 12;
    localparam int BASE_PIXELS  = 9;
    localparam int FRAME_PIXELS = KEY_PIXELS + BASE_PIXELS;
    localparam int QUEUE_DEPTH  = 2;

    localparam int KEY_W = 12;
    localparam int IDX_W = 5;
    localparam int COL_W = 8;

    localparam logic [7:0] SCAN_PERIOD_RESET = 8'd3;
    localparam logic [7:0] SCAN_POS_RESET    = 8'hFB;   // -5
    localparam logic signed [7:0] SCAN_TOP   = 8'sd8;

    localparam logic [7:0] LVL_0x10 = 8'h10;
    localparam logic [7:0] LVL_0x20 = 8'h20;
    localparam logic [7:0] LVL_0x40 = 8'h40;
    localparam logic [7:0] LVL_0x80 = 8'h80;

    typedef enum logic [1:0] {
        MODE_SOLID   = 2'd0,
        MODE_SCANNER = 2'd1,
        MODE_NONE    = 2'd2
    } mode_t;

    // What the nine base pixels currently show
    typedef enum logic [1:0] {
        BASE_BLACK   = 2'd0,
        BASE_RED     = 2'd1,
        BASE_PATTERN = 2'd2
    } base_kind_t;

    typedef enum logic {
        BACK_IDLE = 1'b0,
        BACK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [KEY_W-1:0] keys;
        base_kind_t       kind;
        logic [7:0]       pos;
    } frame_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] blue;
    } grb_t;

    function automatic logic [COL_W-1:0] pat_green(input logic [2:0] k);
        logic [COL_W-1:0] v;
        case (k)
            3'd2:    v = LVL_0x10;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [COL_W-1:0] pat_blue(input logic [2:0] k);
        logic [COL_W-1:0] v;
        case (k)
            3'd0:    v = LVL_0x10;
            3'd1:    v = LVL_0x20;
            3'd2:    v = LVL_0x40;
            3'd3:    v = LVL_0x20;
            3'd4:    v = LVL_0x10;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Color of pixel idx of a frame
    function automatic grb_t pixel_color(input frame_desc_t d, input logic [IDX_W-1:0] idx);
        grb_t             c;
        logic [IDX_W-1:0] j;
        logic signed [9:0] diff;
        c    = '0;
        j    = idx - IDX_W'(KEY_PIXELS);
        diff = $signed({5'b0, j}) - $signed({{2{d.pos[7]}}, d.pos});
        if (idx < IDX_W'(KEY_PIXELS)) begin
            if (d.keys[idx[3:0]]) begin
                case (idx[1:0])
                    2'd0:    c.red   = LVL_0x80;
                    2'd1:    c.green = LVL_0x80;
                    2'd2:    c.blue  = LVL_0x80;
                    default: begin
                        c.red  = LVL_0x80;
                        c.blue = LVL_0x80;
                    end
                endcase
            end
        end else begin
            case (d.kind)
                BASE_RED:     c.red = LVL_0x40;
                BASE_PATTERN: begin
                    if (diff >= 10'sd0 && diff < 10'sd5) begin
                        c.green = pat_green(diff[2:0]);
                        c.blue  = pat_blue(diff[2:0]);
                    end
                end
                default:      c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/klfc_front.sv
// ---------------------------------------------------------------------------
// klfc_front: frame tick intake
// Updates mode, scanner and base state per tick and pushes a frame descriptor.
// ---------------------------------------------------------------------------
`default_nettype none

module klfc_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [klfc_pkg::KEY_W-1:0]    key_matrix,
    input  wire klfc_pkg::q_stat_t             q_stat,
    output logic                               push,
    output klfc_pkg::frame_desc_t              push_desc
);

    logic [7:0]            period_reg;
    klfc_pkg::mode_t       mode_reg, mode_next;
    logic [7:0]            pos_reg, pos_next;
    logic                  up_reg, up_next;
    logic [7:0]            cd_reg, cd_next;
    klfc_pkg::base_kind_t  kind_reg, kind_next;
    logic [7:0]            cd_dec;

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;
    assign cd_dec   = cd_reg - 8'd1;

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        up_next   = up_reg;
        cd_next   = cd_reg;
        kind_next = kind_reg;
        case (mode_reg)
            klfc_pkg::MODE_SCANNER: begin
                cd_next = cd_dec;
                if (cd_dec == 8'd0) begin
                    pos_next  = up_reg ? (pos_reg + 8'd1) : (pos_reg - 8'd1);
                    cd_next   = period_reg;
                    kind_next = klfc_pkg::BASE_PATTERN;
                    if ($signed(pos_next) > klfc_pkg::SCAN_TOP)
                        up_next = 1'b0;
                    else if (pos_next == klfc_pkg::SCAN_POS_RESET)
                        up_next = 1'b1;
                end
            end
            klfc_pkg::MODE_SOLID: kind_next = klfc_pkg::BASE_RED;
            default:              kind_next = klfc_pkg::BASE_BLACK;
        endcase
        // mode keys on row 0, highest column wins
        if (key_matrix[0])
        begin
            up_next   = 1'b1;
            mode_next = klfc_pkg::MODE_SOLID;
        end
        if (key_matrix[1])
            mode_next = klfc_pkg::MODE_SCANNER;
        if (key_matrix[2])
            mode_next = klfc_pkg::MODE_NONE;
    end

    assign push_desc.keys = key_matrix;
    assign push_desc.kind = kind_next;
    assign push_desc.pos  = pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= klfc_pkg::SCAN_PERIOD_RESET;
            mode_reg   <= klfc_pkg::MODE_SCANNER;
            pos_reg    <= klfc_pkg::SCAN_POS_RESET;
            up_reg     <= 1'b1;
            cd_reg     <= klfc_pkg::SCAN_PERIOD_RESET;
            kind_reg   <= klfc_pkg::BASE_BLACK;
        end
        else
        begin
            if (cfg_valid)
                period_reg <= cfg_data;
            if (push)
            begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                up_reg   <= up_next;
                cd_reg   <= cd_next;
                kind_reg <= kind_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/klfc_queue.sv
// ---------------------------------------------------------------------------
// klfc_queue: frame descriptor queue
// Short FIFO between the intake and the pixel sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module klfc_queue #(
    parameter int DEPTH = klfc_pkg::QUEUE_DEPTH
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire klfc_pkg::frame_desc_t   push_desc,
    input  wire logic                    pop,
    output klfc_pkg::frame_desc_t        head_desc,
    output klfc_pkg::q_stat_t            q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    klfc_pkg::frame_desc_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_desc    = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/klfc_back.sv
// ---------------------------------------------------------------------------
// klfc_back: pixel sequencer
// Walks one frame descriptor through its 21 pixels into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module klfc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire klfc_pkg::q_stat_t             q_stat,
    input  wire klfc_pkg::frame_desc_t         head_desc,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [klfc_pkg::IDX_W-1:0]         pixel_index,
    output logic [klfc_pkg::COL_W-1:0]         green_level,
    output logic [klfc_pkg::COL_W-1:0]         red_level,
    output logic [klfc_pkg::COL_W-1:0]         blue_level,
    output logic                               last_pixel
);

    localparam logic [klfc_pkg::IDX_W-1:0] LAST_IDX =
        klfc_pkg::IDX_W'(klfc_pkg::FRAME_PIXELS - 1);

    klfc_pkg::back_state_t         state_reg, state_next;
    klfc_pkg::frame_desc_t         desc_reg;
    logic [klfc_pkg::IDX_W-1:0]    idx_reg;
    logic                          out_valid_reg;
    logic [klfc_pkg::IDX_W-1:0]    pix_idx_reg;
    klfc_pkg::grb_t                pix_reg;
    logic                          pix_last_reg;
    logic                          load, emit, at_last;

    assign load    = !out_valid_reg || !out_stall;
    assign at_last = (idx_reg == LAST_IDX);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            klfc_pkg::BACK_IDLE: begin
                if (!q_stat.empty)
                    state_next = klfc_pkg::BACK_RUN;
            end
            klfc_pkg::BACK_RUN: begin
                if (load && at_last && q_stat.empty)
                    state_next = klfc_pkg::BACK_IDLE;
            end
            default: state_next = klfc_pkg::BACK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            klfc_pkg::BACK_IDLE: pop = !q_stat.empty;
            klfc_pkg::BACK_RUN: begin
                emit = load;
                pop  = load && at_last && !q_stat.empty;
            end
            default: begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= klfc_pkg::BACK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                idx_reg <= '0;
            else if (emit)
                idx_reg <= idx_reg + 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (load)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            desc_reg <= head_desc;
        if (emit)
        begin
            pix_idx_reg  <= idx_reg;
            pix_reg      <= klfc_pkg::pixel_color(desc_reg, idx_reg);
            pix_last_reg <= at_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pix_idx_reg;
    assign green_level = pix_reg.green;
    assign red_level   = pix_reg.red;
    assign blue_level  = pix_reg.blue;
    assign last_pixel  = pix_last_reg;

endmodule

`default_nettype wire

>>> rtl/keypad_led_frame_composer_unit.sv
// A frame passes the queue entry, the descriptor register and the output
// register. Throughput: one pixel per cycle while out_stall is low, set by
// the pixel sequencer; up to two frame descriptors wait in the queue ahead
// of it. The intake stalls only while that queue is full.
// Reset (rst_n low, asynchronous): scanner mode, position -5, upward,
// countdown 3, scan_period 3, base pixels black, queue and outputs empty.
// ---------------------------------------------------------------------------
// keypad_led_frame_composer_unit: keypad LED frame composer top level
// Turns each key-matrix frame tick into 21 GRB pixel transfers.
// ---------------------------------------------------------------------------
`default_nettype none

module keypad_led_frame_composer_unit #(
    parameter int QUEUE_DEPTH = klfc_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration: scan_period
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [7:0]                    cfg_data,
    // frame tick input
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [klfc_pkg::KEY_W-1:0]    key_matrix,
    // pixel output
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [klfc_pkg::IDX_W-1:0]         pixel_index,
    output logic [klfc_pkg::COL_W-1:0]         green_level,
    output logic [klfc_pkg::COL_W-1:0]         red_level,
    output logic [klfc_pkg::COL_W-1:0]         blue_level,
    output logic                               last_pixel
);

    klfc_pkg::q_stat_t     q_stat;
    klfc_pkg::frame_desc_t push_desc;
    klfc_pkg::frame_desc_t head_desc;
    logic                  push;
    logic                  pop;

    // Register writes are captured at the clock edge; the port never back-pressures.
    assign cfg_ready = 1'b1;

    // Front: applies base mode and scanner step at transfer time, captures
    // keys plus that base picture as a descriptor, then applies mode keys.
    klfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_matrix (key_matrix),
        .q_stat     (q_stat),
        .push       (push),
        .push_desc  (push_desc)
    );

    // Decouples the intake from pixel streaming.
    klfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .q_stat    (q_stat)
    );

    // Back: key pixels 0-11, then base pixels 12-20, one per cycle through
    // a registered output stage held while out_stall is high.
    klfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head_desc   (head_desc),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .green_level (green_level),
        .red_level   (red_level),
        .blue_level  (blue_level),
        .last_pixel  (last_pixel)
    );

endmodule

`default_nettype wire

>>> rtl/klfc_checker.sv
// ---------------------------------------------------------------------------
// klfc_checker: port-level checks for the frame composer
// Watches the output channel of the top level; bound in below.
// ---------------------------------------------------------------------------
`default_nettype none

module klfc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [klfc_pkg::IDX_W-1:0]    pixel_index,
    input wire logic [klfc_pkg::COL_W-1:0]    green_level,
    input wire logic [klfc_pkg::COL_W-1:0]    red_level,
    input wire logic [klfc_pkg::COL_W-1:0]    blue_level,
    input wire logic                          last_pixel
);

    localparam logic [klfc_pkg::IDX_W-1:0] LAST_IDX =
        klfc_pkg::IDX_W'(klfc_pkg::FRAME_PIXELS - 1);
    localparam logic [klfc_pkg::IDX_W-1:0] FIRST_BASE =
        klfc_pkg::IDX_W'(klfc_pkg::KEY_PIXELS);

    // stalled transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_index)
            && $stable(green_level) && $stable(red_level) && $stable(blue_level))
        else $error("stalled pixel changed");

    // frame end flag matches the final index
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_pixel == (pixel_index == LAST_IDX)) && pixel_index <= LAST_IDX)
        else $error("last_pixel or pixel_index out of place");

    // indexes step by one within a frame
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_pixel ##1 out_valid
            |-> pixel_index == $past(pixel_index) + 1'b1)
        else $error("pixel index skipped");

    // key pixels carry only full-level channels
    a_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_index < FIRST_BASE
            |-> (green_level == 8'h00 || green_level == 8'h80)
             && (red_level == 8'h00 || red_level == 8'h80)
             && (blue_level == 8'h00 || blue_level == 8'h80))
        else $error("key pixel color out of range");

endmodule

bind keypad_led_frame_composer_unit klfc_checker u_klfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .green_level (green_level),
    .red_level   (red_level),
    .blue_level  (blue_level),
    .last_pixel  (last_pixel)
);

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for keypad_led_frame_composer_unit
// Drives key-matrix frame ticks and scan_period writes, predicts every GRB
// pixel of every frame and checks the pixel stream field by field.
// ---------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import klfc_pkg::*;

    // Base colors the directed table can state outright
    localparam grb_t BASE_DARK  = '0;
    localparam grb_t BASE_SOLID = {8'h00, LVL_0x40, 8'h00};

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int MAX_PRINTED     = 40;

    typedef enum logic {
        STEP_FRAME  = 1'b0,
        STEP_PERIOD = 1'b1
    } step_kind_t;

    // One row of the directed table: a frame tick or a scan_period write.
    // typed rows carry the expected base color instead of the predicted one.
    typedef struct packed {
        step_kind_t       kind;
        logic [KEY_W-1:0] value;
        logic             typed;
        grb_t             base;
    } step_t;

    // One expected pixel transfer
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        grb_t             color;
        logic             last;
    } led_word_t;

    // -----------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // -----------------------------------------------------------------------
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    logic [7:0]       cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [KEY_W-1:0] key_matrix = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [IDX_W-1:0] pixel_index;
    logic [COL_W-1:0] green_level;
    logic [COL_W-1:0] red_level;
    logic [COL_W-1:0] blue_level;
    logic             last_pixel;

    always #6 clk = ~clk;

    keypad_led_frame_composer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .key_matrix  (key_matrix),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .green_level (green_level),
        .red_level   (red_level),
        .blue_level  (blue_level),
        .last_pixel  (last_pixel)
    );

    // -----------------------------------------------------------------------
    // Predictor state: a private copy of the frame composer
    // -----------------------------------------------------------------------
    mode_t      pred_mode;
    logic [7:0] pred_pos;        // two's complement sweep position
    logic       pred_up;
    logic [7:0] pred_countdown;
    logic [7:0] pred_period;
    grb_t       pred_base [BASE_PIXELS];

    led_word_t  led_expect_q[$];
    step_t      plan_q[$];

    int  error_count   = 0;
    int  frames_sent   = 0;
    int  pixels_seen   = 0;
    int  sweep_moves   = 0;
    int  sweep_turns   = 0;
    int  solid_frames  = 0;
    int  dark_frames   = 0;
    int  period_writes = 0;
    bit  tx_idle_on    = 1'b0;
    bit  rx_idle_on    = 1'b0;
    int  hold_requests = 0;      // bumped by the stimulus, served by the receiver
    int  holds_served  = 0;
    int  hold_left     = 0;
    int  stall_left    = 0;

    // -----------------------------------------------------------------------
    // Predictor helpers
    // -----------------------------------------------------------------------

    // Key pixel: column picks the color, all at 0x80
    function automatic grb_t key_led(input logic [KEY_W-1:0] keys, input int col_idx);
        grb_t c;
        c = '0;
        if (keys[col_idx]) begin
            case (col_idx % 4)
                0: c.red   = LVL_0x80;
                1: c.green = LVL_0x80;
                2: c.blue  = LVL_0x80;
                default: begin
                    c.red  = LVL_0x80;
                    c.blue = LVL_0x80;
                end
            endcase
        end
        return c;
    endfunction

    // Five-pixel sweep: blue ramp 10/20/40/20/10 with green 10 in the middle
    function automatic grb_t sweep_led(input int k);
        grb_t c;
        c = '0;
        case (k)
            0, 4: c.blue = LVL_0x10;
            1, 3: c.blue = LVL_0x20;
            default: begin
                c.blue  = LVL_0x40;
                c.green = LVL_0x10;
            end
        endcase
        return c;
    endfunction

    task automatic reset_predictor;
        pred_mode      = MODE_SCANNER;
        pred_pos       = SCAN_POS_RESET;
        pred_up        = 1'b1;
        pred_countdown = SCAN_PERIOD_RESET;
        pred_period    = SCAN_PERIOD_RESET;
        foreach (pred_base[i]) pred_base[i] = '0;
    endtask

    // Advance the composer by one frame tick and queue its 21 pixels
    task automatic predict_frame(input logic [KEY_W-1:0] keys, input bit typed,
                                 input grb_t typed_base);
        int        spos;
        int        p;
        led_word_t w;
        case (pred_mode)
            MODE_SCANNER: begin
                pred_countdown = pred_countdown - 8'd1;
                if (pred_countdown == 8'd0) begin
                    pred_pos       = pred_pos + (pred_up ? 8'd1 : 8'hFF);
                    pred_countdown = pred_period;
                    sweep_moves++;
                    foreach (pred_base[i]) pred_base[i] = '0;
                    spos = $signed(pred_pos);
                    for (int k = 0; k < 5; k++) begin
                        p = spos + k;
                        if (p >= 0 && p < BASE_PIXELS) pred_base[p] = sweep_led(k);
                    end
                    // turn around past the top end, or back at the bottom end
                    if (spos > 8) begin
                        if (pred_up) sweep_turns++;
                        pred_up = 1'b0;
                    end else if (spos == -5) begin
                        if (!pred_up) sweep_turns++;
                        pred_up = 1'b1;
                    end
                end
            end
            MODE_SOLID: begin
                foreach (pred_base[i]) pred_base[i] = BASE_SOLID;
                solid_frames++;
            end
            default: begin
                foreach (pred_base[i]) pred_base[i] = '0;
                dark_frames++;
            end
        endcase

        // mode keys on row 0, highest column wins; solid also points the sweep up
        if (keys[0]) begin
            pred_up   = 1'b1;
            pred_mode = MODE_SOLID;
        end
        if (keys[1]) pred_mode = MODE_SCANNER;
        if (keys[2]) pred_mode = MODE_NONE;

        for (int i = 0; i < FRAME_PIXELS; i++) begin
            w.idx  = IDX_W'(i);
            w.last = (i == FRAME_PIXELS - 1);
            if (i < KEY_PIXELS)
                w.color = key_led(keys, i);
            else
                w.color = typed ? typed_base : pred_base[i - KEY_PIXELS];
            led_expect_q.push_back(w);
        end
    endtask

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (error_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h (pixel transfer %0d)",
                     $realtime, what, got, want, pixels_seen);
        error_count++;
    endtask

    // Every accepted pixel transfer is matched against the oldest expectation
    always @(posedge clk) begin : pixel_check
        led_word_t want;
        if (rst_n && out_valid && !out_stall) begin
            pixels_seen++;
            if (led_expect_q.size() == 0) begin
                note_mismatch("pixel with nothing expected", pixel_index, 0);
            end else begin
                want = led_expect_q.pop_front();
                if (pixel_index !== want.idx)
                    note_mismatch("pixel_index", pixel_index, want.idx);
                if (green_level !== want.color.green)
                    note_mismatch("green_level", green_level, want.color.green);
                if (red_level !== want.color.red)
                    note_mismatch("red_level", red_level, want.color.red);
                if (blue_level !== want.color.blue)
                    note_mismatch("blue_level", blue_level, want.color.blue);
                if (last_pixel !== want.last)
                    note_mismatch("last_pixel", last_pixel, want.last);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request so the
    // frame queue fills and the intake has to stall.
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_OFF_CYCLES - 1;
            out_stall    <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // One frame tick transfer; valid stays up afterwards so back-to-back
    // frames need no second assignment in the same step
    task automatic send_frame(input logic [KEY_W-1:0] keys, input bit typed,
                              input grb_t typed_base);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_matrix <= keys;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_frame(keys, typed, typed_base);
        frames_sent++;
    endtask

    // Stop offering frames until every queued pixel has come out
    task automatic wait_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (led_expect_q.size() != 0) @(posedge clk);
    endtask

    // scan_period write; only called with the block idle
    task automatic write_period(input logic [7:0] period);
        cfg_valid <= 1'b1;
        cfg_data  <= period;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        pred_period = period;
        period_writes++;
    endtask

    // Mostly keys that leave the sweep running (row 0 quiet, or only the
    // scanner key), some single mode presses, some fully random matrices
    function automatic logic [KEY_W-1:0] random_keys();
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(0, 99);
        k = KEY_W'($urandom_range(0, 4095));
        if (r < 65) begin
            k[2:0] = ($urandom_range(0, 5) == 0) ? 3'b010 : 3'b000;
        end else if (r < 85) begin
            case ($urandom_range(0, 3))
                0:       k[2:0] = 3'b001;
                3:       k[2:0] = 3'b100;
                default: k[2:0] = 3'b010;
            endcase
        end
        return k;
    endfunction

    task automatic run_phase(input logic [7:0] period, input int count, input bit idle,
                             input bit squeeze);
        wait_drained();
        write_period(period);
        tx_idle_on = idle;
        rx_idle_on = idle;
        // long receiver hold-off while frames keep coming
        if (squeeze) hold_requests++;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_drained();
            send_frame(random_keys(), 1'b0, BASE_DARK);
        end
    endtask

    task automatic add_step(input step_kind_t kind, input logic [KEY_W-1:0] value,
                            input bit typed, input grb_t base);
        step_t s;
        s.kind  = kind;
        s.value = value;
        s.typed = typed;
        s.base  = base;
        plan_q.push_back(s);
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        reset_predictor();

        // Directed table. From reset the sweep makes its first move on the third
        // tick, so the first two frames have a dark base.
        add_step(STEP_FRAME,  12'h000, 1'b1, BASE_DARK);
        add_step(STEP_FRAME,  12'h000, 1'b1, BASE_DARK);
        add_step(STEP_FRAME,  12'h000, 1'b0, BASE_DARK);  // first sweep move
        add_step(STEP_FRAME,  12'hFFF, 1'b0, BASE_DARK);  // all keys: none mode wins
        add_step(STEP_FRAME,  12'h000, 1'b1, BASE_DARK);
        add_step(STEP_FRAME,  12'h001, 1'b1, BASE_DARK);  // solid key alone
        add_step(STEP_FRAME,  12'h000, 1'b1, BASE_SOLID);
        add_step(STEP_FRAME,  12'h800, 1'b1, BASE_SOLID);
        add_step(STEP_FRAME,  12'hFF8, 1'b1, BASE_SOLID); // every non-mode key
        add_step(STEP_FRAME,  12'h005, 1'b1, BASE_SOLID); // solid then none: none wins
        add_step(STEP_FRAME,  12'h003, 1'b1, BASE_DARK);  // solid then scanner
        add_step(STEP_FRAME,  12'h006, 1'b0, BASE_DARK);  // scanner then none
        add_step(STEP_FRAME,  12'h002, 1'b1, BASE_DARK);
        add_step(STEP_PERIOD, 12'h001, 1'b0, BASE_DARK);  // shortest period
        add_step(STEP_FRAME,  12'h000, 1'b0, BASE_DARK);
        add_step(STEP_FRAME,  12'h010, 1'b0, BASE_DARK);
        add_step(STEP_FRAME,  12'h100, 1'b0, BASE_DARK);
        add_step(STEP_FRAME,  12'h0F0, 1'b0, BASE_DARK);
        add_step(STEP_FRAME,  12'h555, 1'b0, BASE_DARK);
        add_step(STEP_FRAME,  12'hAAA, 1'b0, BASE_DARK);
        add_step(STEP_FRAME,  12'h008, 1'b0, BASE_DARK);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (plan_q[i]) begin
            if (plan_q[i].kind == STEP_PERIOD) begin
                wait_drained();
                write_period(plan_q[i].value[7:0]);
            end else begin
                send_frame(plan_q[i].value, plan_q[i].typed, plan_q[i].base);
            end
        end

        // Random part: several scan periods, the extremes among them.
        // Period 1 lets the sweep bounce end to end a few times.
        run_phase(8'd1,   45, 1'b1, 1'b0);
        run_phase(8'd255, 10, 1'b1, 1'b0);
        run_phase(8'd2,   15, 1'b0, 1'b0);
        run_phase(8'($urandom_range(1, 6)), 25, 1'b1, 1'b1);
        // last stretch runs without any idling
        run_phase(SCAN_PERIOD_RESET, 15, 1'b0, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (led_expect_q.size() != 0)
            note_mismatch("pixels never delivered", 0, led_expect_q.size());

        $display("Run covered %0d frame ticks, %0d pixel transfers, %0d scan_period writes.",
                 frames_sent, pixels_seen, period_writes);
        $display("Sweep moved %0d times and turned %0d times; %0d solid and %0d dark frames.",
                 sweep_moves, sweep_turns, solid_frames, dark_frames);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Timeout with %0d pixels still expected", led_expect_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
